FILE: rtl/ehv_pkg.sv
// ----------------------------------------------------------------------------
// ehv_pkg
// Shared types and constants of the ELF header validator: status codes,
// header layout sizes and the captured header field record.
// ----------------------------------------------------------------------------
`default_nettype none

package ehv_pkg;

    localparam int unsigned HDR_BYTES   = 64;
    localparam int unsigned COUNT_W     = 7;

    localparam logic [31:0] IDENT_BYTES = 32'd16;
    localparam logic [6:0]  EH32_BYTES  = 7'd52;
    localparam logic [6:0]  EH64_BYTES  = 7'd64;

    localparam logic [7:0]  CLASS_32    = 8'd1;
    localparam logic [7:0]  CLASS_64    = 8'd2;
    localparam logic [7:0]  DATA_LSB    = 8'd1;
    // Magic bytes packed little-endian: 7F 'E' 'L' 'F'.
    localparam logic [31:0] ELF_MAGIC   = 32'h464C_457F;

    localparam logic [3:0]  ST_OK         = 4'd0;
    localparam logic [3:0]  ST_TOO_SMALL  = 4'd1;
    localparam logic [3:0]  ST_BAD_MAGIC  = 4'd2;
    localparam logic [3:0]  ST_NOT_LE     = 4'd3;
    localparam logic [3:0]  ST_BAD_CLASS  = 4'd4;
    localparam logic [3:0]  ST_TRUNCATED  = 4'd5;
    localparam logic [3:0]  ST_BAD_EHSIZE = 4'd6;
    localparam logic [3:0]  ST_BAD_PHDR   = 4'd7;
    localparam logic [3:0]  ST_BAD_SHDR   = 4'd8;

    localparam logic [0:0]  REG_IMAGE_SIZE = 1'b0;

    typedef struct packed {
        logic [31:0] magic;
        logic [7:0]  cls;
        logic [7:0]  data_enc;
        logic [15:0] file_type;
        logic [15:0] machine;
        logic [63:0] entry;
        logic [63:0] phoff;
        logic [63:0] shoff;
        logic [15:0] ehsize;
        logic [15:0] phentsize;
        logic [15:0] phnum;
        logic [15:0] shentsize;
        logic [15:0] shnum;
    } hdr_fields_t;

endpackage

`default_nettype wire

FILE: rtl/ehv_in_if.sv
// ----------------------------------------------------------------------------
// ehv_in_if
// Byte stream channel into the validator: one image byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       last_byte;

    modport source (output valid, output header_byte, output last_byte, input ready);
    modport sink   (input valid, input header_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/ehv_out_if.sv
// ----------------------------------------------------------------------------
// ehv_out_if
// Result channel of the validator: one item per image.
// ----------------------------------------------------------------------------
`default_nettype none

interface ehv_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic        is_64bit;
    logic [15:0] machine;
    logic [15:0] file_type;
    logic [63:0] entry_point;

    modport source (output valid, output status, output is_64bit, output machine,
                    output file_type, output entry_point, input ready);
    modport sink   (input valid, input status, input is_64bit, input machine,
                    input file_type, input entry_point, output ready);
endinterface

`default_nettype wire

FILE: rtl/ehv_cfg.sv
// ----------------------------------------------------------------------------
// ehv_cfg
// APB register file holding the image size.
// ----------------------------------------------------------------------------
`default_nettype none

module ehv_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output logic [31:0]      image_size
);
    import ehv_pkg::*;

    logic [31:0] image_size_reg;
    logic [31:0] image_size_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_IMAGE_SIZE);

    always_comb
    begin
        image_size_next = image_size_reg;
        if (wr_en)
        begin
            image_size_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg <= '0;
        end
        else
        begin
            image_size_reg <= image_size_next;
        end
    end

    assign prdata     = (paddr[2] == REG_IMAGE_SIZE) ? image_size_reg : '0;
    assign image_size = image_size_reg;

endmodule

`default_nettype wire

FILE: rtl/ehv_capture.sv
// ----------------------------------------------------------------------------
// ehv_capture
// Byte counter and field capture: each incoming byte is routed into the
// header field it belongs to, using the class byte for the layout.
// ----------------------------------------------------------------------------
`default_nettype none

module ehv_capture (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic [7:0]          header_byte,
    input  wire logic                last_byte,
    output ehv_pkg::hdr_fields_t     fields
);
    import ehv_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    hdr_fields_t        fields_reg;
    hdr_fields_t        fields_next;
    logic [5:0]         off;
    logic               store;
    logic               wide;

    assign off   = count_reg[5:0];
    assign store = fire && !count_reg[COUNT_W-1];
    assign wide  = (fields_reg.cls == CLASS_64);

    always_comb
    begin
        count_next = count_reg;
        if (fire)
        begin
            if (last_byte)
            begin
                count_next = '0;
            end
            else if (!count_reg[COUNT_W-1])
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Fields start from zero on the first byte of an image, so offsets that
    // never arrive read as zero.
    always_comb
    begin
        fields_next = (count_reg == '0) ? '0 : fields_reg;
        if (store)
        begin
            if (off < 6'd4)
            begin
                fields_next.magic[{off[1:0], 3'b000} +: 8] = header_byte;
            end
            if (off == 6'd4)
            begin
                fields_next.cls = header_byte;
            end
            if (off == 6'd5)
            begin
                fields_next.data_enc = header_byte;
            end
            if (off == 6'd16 || off == 6'd17)
            begin
                fields_next.file_type[{off[0], 3'b000} +: 8] = header_byte;
            end
            if (off == 6'd18 || off == 6'd19)
            begin
                fields_next.machine[{off[0], 3'b000} +: 8] = header_byte;
            end
            if (off >= 6'd24 && off < 6'd32)
            begin
                fields_next.entry[{off[2:0], 3'b000} +: 8] = header_byte;
            end
            if (wide)
            begin
                if (off >= 6'd32 && off < 6'd40)
                begin
                    fields_next.phoff[{off[2:0], 3'b000} +: 8] = header_byte;
                end
                if (off >= 6'd40 && off < 6'd48)
                begin
                    fields_next.shoff[{off[2:0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd52 || off == 6'd53)
                begin
                    fields_next.ehsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd54 || off == 6'd55)
                begin
                    fields_next.phentsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd56 || off == 6'd57)
                begin
                    fields_next.phnum[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd58 || off == 6'd59)
                begin
                    fields_next.shentsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd60 || off == 6'd61)
                begin
                    fields_next.shnum[{off[0], 3'b000} +: 8] = header_byte;
                end
            end
            else
            begin
                if (off >= 6'd28 && off < 6'd32)
                begin
                    fields_next.phoff[{off[1:0], 3'b000} +: 8] = header_byte;
                end
                if (off >= 6'd32 && off < 6'd36)
                begin
                    fields_next.shoff[{off[1:0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd40 || off == 6'd41)
                begin
                    fields_next.ehsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd42 || off == 6'd43)
                begin
                    fields_next.phentsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd44 || off == 6'd45)
                begin
                    fields_next.phnum[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd46 || off == 6'd47)
                begin
                    fields_next.shentsize[{off[0], 3'b000} +: 8] = header_byte;
                end
                if (off == 6'd48 || off == 6'd49)
                begin
                    fields_next.shnum[{off[0], 3'b000} +: 8] = header_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            fields_reg <= fields_next;
        end
    end

    assign fields = fields_reg;

endmodule

`default_nettype wire

FILE: rtl/ehv_check.sv
// ----------------------------------------------------------------------------
// ehv_check
// Check sequencer: one shared multiply and add-compare unit tests the
// program and section header tables in turn, then the result register is
// loaded with the prioritized status and, if it is OK, the header fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ehv_check (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire ehv_pkg::hdr_fields_t fields,
    input  wire logic [31:0]          image_size,
    output logic                      busy,
    ehv_out_if.source                 out_ch
);
    import ehv_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PH_MUL = 6'b000010,
        S_PH_CMP = 6'b000100,
        S_SH_MUL = 6'b001000,
        S_SH_CMP = 6'b010000,
        S_DONE   = 6'b100000
    } chk_state_t;

    chk_state_t  state_reg;
    chk_state_t  state_next;
    logic [31:0] prod_reg;
    logic [31:0] prod_next;
    logic        ph_bad_reg;
    logic        ph_bad_next;
    logic        sh_bad_reg;
    logic        sh_bad_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [3:0]  status_reg;
    logic        is_64bit_reg;
    logic [15:0] machine_reg;
    logic [15:0] file_type_reg;
    logic [63:0] entry_reg;

    logic        sel_sh;
    logic [15:0] ent;
    logic [15:0] num;
    logic [63:0] toff;
    logic [64:0] tend;
    logic        tbl_bad;
    logic        wide;
    logic [6:0]  hdr_len;
    logic [3:0]  status_calc;
    logic        load_out;

    // Shared table unit: the sequencer picks which table feeds it.
    assign sel_sh  = (state_reg == S_SH_MUL) || (state_reg == S_SH_CMP);
    assign ent     = sel_sh ? fields.shentsize : fields.phentsize;
    assign num     = sel_sh ? fields.shnum : fields.phnum;
    assign toff    = sel_sh ? fields.shoff : fields.phoff;
    assign tend    = {1'b0, toff} + {33'b0, prod_reg};
    assign tbl_bad = (num != '0) && ((ent == '0) || (tend > {33'b0, image_size}));

    assign wide    = (fields.cls == CLASS_64);
    assign hdr_len = wide ? EH64_BYTES : EH32_BYTES;

    always_comb
    begin
        priority if (image_size < IDENT_BYTES)
            status_calc = ST_TOO_SMALL;
        else if (fields.magic != ELF_MAGIC)
            status_calc = ST_BAD_MAGIC;
        else if (fields.data_enc != DATA_LSB)
            status_calc = ST_NOT_LE;
        else if (fields.cls != CLASS_32 && fields.cls != CLASS_64)
            status_calc = ST_BAD_CLASS;
        else if (image_size < {25'b0, hdr_len})
            status_calc = ST_TRUNCATED;
        else if (fields.ehsize < {9'b0, hdr_len})
            status_calc = ST_BAD_EHSIZE;
        else if (ph_bad_reg)
            status_calc = ST_BAD_PHDR;
        else if (sh_bad_reg)
            status_calc = ST_BAD_SHDR;
        else
            status_calc = ST_OK;
    end

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next  = state_reg;
        prod_next   = prod_reg;
        ph_bad_next = ph_bad_reg;
        sh_bad_next = sh_bad_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_PH_MUL;
                end
            end
            S_PH_MUL:
            begin
                prod_next  = {16'b0, ent} * {16'b0, num};
                state_next = S_PH_CMP;
            end
            S_PH_CMP:
            begin
                ph_bad_next = tbl_bad;
                state_next  = S_SH_MUL;
            end
            S_SH_MUL:
            begin
                prod_next  = {16'b0, ent} * {16'b0, num};
                state_next = S_SH_CMP;
            end
            S_SH_CMP:
            begin
                sh_bad_next = tbl_bad;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        ph_bad_reg <= ph_bad_next;
        sh_bad_reg <= sh_bad_next;
        if (load_out)
        begin
            status_reg   <= status_calc;
            is_64bit_reg <= wide;
            if (status_calc == ST_OK)
            begin
                machine_reg   <= fields.machine;
                file_type_reg <= fields.file_type;
                entry_reg     <= wide ? fields.entry : {32'b0, fields.entry[31:0]};
            end
            else
            begin
                machine_reg   <= '0;
                file_type_reg <= '0;
                entry_reg     <= '0;
            end
        end
    end

    assign busy               = (state_reg != S_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.status      = status_reg;
    assign out_ch.is_64bit    = is_64bit_reg;
    assign out_ch.machine     = machine_reg;
    assign out_ch.file_type   = file_type_reg;
    assign out_ch.entry_point = entry_reg;

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("check sequencer state is not one-hot");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("check started while sequencer busy");

    a_cmp_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_CMP) |-> $past(state_reg == S_SH_MUL))
        else $error("section compare without a fresh product");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != ST_OK) |->
            (machine_reg == '0 && file_type_reg == '0 && entry_reg == '0))
        else $error("header fields given with a failing status");

    a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result shown outside the done step");

endmodule

`default_nettype wire

FILE: rtl/elf_header_validator.sv
// ----------------------------------------------------------------------------
// elf_header_validator
// Validates a little-endian ELF32/ELF64 header streamed in one byte per item.
//
// Usage: write the total image length to the image_size register over APB
// (byte address 0) while the block is idle. Then stream the first
// min(image_size, 64) bytes on in_ch, one byte per cycle, with last_byte set
// on the final one. Non-final bytes are taken every cycle. After the final
// byte, in_ch.ready drops while the shared multiply and add-compare unit
// checks the program and section header tables one after the other; the
// result item is then loaded into the out_ch register. A new image may
// start as soon as the result is loaded, even while the result still waits
// on out_ch. If out_ch stalls with a result pending, the next image's
// result is held in the sequencer and in_ch stays low-ready until the
// output register frees up.
// Reset clears the byte count, the sequencer, the result valid and
// image_size; the first byte after reset starts a new image.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_header_validator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ehv_in_if.sink           in_ch,
    ehv_out_if.source        out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ehv_pkg::*;

    hdr_fields_t fields;
    logic [31:0] image_size;
    logic        busy;
    logic        fire;

    assign in_ch.ready = !busy;
    assign fire        = in_ch.valid && !busy;

    ehv_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .image_size (image_size)
    );

    ehv_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .header_byte (in_ch.header_byte),
        .last_byte   (in_ch.last_byte),
        .fields      (fields)
    );

    ehv_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fire && in_ch.last_byte),
        .fields     (fields),
        .image_size (image_size),
        .busy       (busy),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for elf_header_validator. Builds ELF32 and ELF64 header
// images with chosen defects, streams them byte by byte with random gaps,
// stalls the result channel, and compares every result item with a local
// prediction of the validator worked out from the bytes actually accepted.
// ----------------------------------------------------------------------------

module testbench;

    import ehv_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          RANDOM_BYTES   = 550;
    localparam logic [2:0]  ADDR_IMAGE_SIZE = 3'(4 * REG_IMAGE_SIZE);
    localparam logic [2:0]  ADDR_UNUSED     = 3'd4;

    typedef enum int {
        MUT_NONE, MUT_MAGIC, MUT_DATA, MUT_CLASS, MUT_EHSIZE,
        MUT_PH_ENT, MUT_PH_RANGE, MUT_SH_ENT, MUT_SH_RANGE, MUT_NO_TABLES
    } hdr_mutation_t;

    typedef enum int {TBL_GOOD, TBL_NO_ENTSIZE, TBL_OUT_OF_RANGE, TBL_EMPTY} table_shape_t;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_SPARSE} stall_mode_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        is_64bit;
        logic [15:0] machine;
        logic [15:0] file_type;
        logic [63:0] entry_point;
    } elf_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ehv_in_if  in_ch();
    ehv_out_if out_ch();

    elf_header_validator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state: bytes of the current image as the block should hold them.
    logic [7:0]  hdr_mem[HDR_BYTES];
    int unsigned hdr_count = 0;
    logic [31:0] cfg_image_size = '0;

    elf_result_t expected_results[$];
    logic [7:0]  image_buf[HDR_BYTES];

    int errors       = 0;
    int bytes_sent   = 0;
    int burst_left   = 0;
    int gap_len      = 0;
    int idle_count   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic logic [7:0] byte_at(input int unsigned off);
        if (off >= hdr_count || off >= HDR_BYTES)
            return 8'h00;
        return hdr_mem[off];
    endfunction

    function automatic logic [63:0] le_field(input int unsigned off, input int unsigned n);
        logic [63:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v |= 64'(byte_at(off + i)) << (8 * i);
        return v;
    endfunction

    function automatic bit span_fits(input logic [63:0] off, input logic [63:0] len);
        logic [63:0] sz;
        sz = {32'h0, cfg_image_size};
        if (off > sz)
            return 1'b0;
        return len <= sz - off;
    endfunction

    function automatic bit table_fits(input logic [63:0] off, input logic [63:0] ent,
                                      input logic [63:0] cnt);
        if (cnt == 0)
            return 1'b1;
        if (ent == 0)
            return 1'b0;
        return span_fits(off, ent * cnt);
    endfunction

    function automatic elf_result_t predict_result();
        elf_result_t r;
        logic [7:0]  cls;
        bit          wide;
        cls = byte_at(4);
        wide = (cls == CLASS_64);
        r.is_64bit    = wide;
        r.machine     = 16'(le_field(18, 2));
        r.file_type   = 16'(le_field(16, 2));
        r.entry_point = wide ? le_field(24, 8) : le_field(24, 4);
        if (cfg_image_size < IDENT_BYTES)
            r.status = ST_TOO_SMALL;
        else if (le_field(0, 4) != {32'h0, ELF_MAGIC})
            r.status = ST_BAD_MAGIC;
        else if (byte_at(5) != DATA_LSB)
            r.status = ST_NOT_LE;
        else if (cls != CLASS_32 && !wide)
            r.status = ST_BAD_CLASS;
        else if (!span_fits(0, wide ? 64'(EH64_BYTES) : 64'(EH32_BYTES)))
            r.status = ST_TRUNCATED;
        else if (wide)
        begin
            if (le_field(52, 2) < 64'(EH64_BYTES))
                r.status = ST_BAD_EHSIZE;
            else if (!table_fits(le_field(32, 8), le_field(54, 2), le_field(56, 2)))
                r.status = ST_BAD_PHDR;
            else if (!table_fits(le_field(40, 8), le_field(58, 2), le_field(60, 2)))
                r.status = ST_BAD_SHDR;
            else
                r.status = ST_OK;
        end
        else
        begin
            if (le_field(40, 2) < 64'(EH32_BYTES))
                r.status = ST_BAD_EHSIZE;
            else if (!table_fits(le_field(28, 4), le_field(42, 2), le_field(44, 2)))
                r.status = ST_BAD_PHDR;
            else if (!table_fits(le_field(32, 4), le_field(46, 2), le_field(48, 2)))
                r.status = ST_BAD_SHDR;
            else
                r.status = ST_OK;
        end
        if (r.status != ST_OK)
        begin
            r.machine     = '0;
            r.file_type   = '0;
            r.entry_point = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Image construction
    // ------------------------------------------------------------------------

    function automatic void put_le(input int unsigned off, input logic [63:0] v,
                                   input int unsigned n);
        for (int i = 0; i < n; i++)
            image_buf[off + i] = v[8 * i +: 8];
    endfunction

    function automatic void gen_table(input bit is64, input table_shape_t shape,
                                      output logic [63:0] off, output logic [15:0] ent,
                                      output logic [15:0] cnt);
        logic [63:0] len;
        logic [63:0] sz;
        sz  = {32'h0, cfg_image_size};
        ent = 16'($urandom_range(1, 64));
        cnt = 16'($urandom_range(1, 8));
        off = is64 ? {$urandom, $urandom} : {32'h0, $urandom};
        len = 64'(ent) * 64'(cnt);
        case (shape)
            TBL_GOOD:
            begin
                if (len > sz)
                    cnt = '0;
                else if ($urandom_range(0, 3) == 0)
                    off = sz - len;
                else
                    off = {32'h0, $urandom_range(0, 32'(sz - len))};
            end
            TBL_NO_ENTSIZE:
            begin
                ent = '0;
                cnt = 16'($urandom_range(1, 65535));
            end
            TBL_OUT_OF_RANGE:
            begin
                // Either one byte past the end, or a wild offset with the drawn or a wild size.
                if ($urandom_range(0, 1) == 1 && len <= sz)
                    off = sz - len + 1;
                else if ($urandom_range(0, 1) == 1)
                begin
                    ent = 16'($urandom_range(1, 65535));
                    cnt = 16'($urandom_range(1, 65535));
                end
            end
            default:
                cnt = '0;
        endcase
    endfunction

    function automatic void build_header(input bit is64, input hdr_mutation_t mut);
        logic [63:0]  ph_off, sh_off;
        logic [15:0]  ph_ent, ph_cnt, sh_ent, sh_cnt, eh_size;
        int unsigned  hsize;
        int unsigned  idx;
        table_shape_t ph_shape, sh_shape;
        for (int i = 0; i < HDR_BYTES; i++)
            image_buf[i] = 8'($urandom);
        hsize = is64 ? EH64_BYTES : EH32_BYTES;
        put_le(0, {32'h0, ELF_MAGIC}, 4);
        image_buf[4] = is64 ? CLASS_64 : CLASS_32;
        image_buf[5] = DATA_LSB;
        eh_size = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(hsize, 65535))
                                              : 16'(hsize);
        ph_shape = TBL_GOOD;
        sh_shape = TBL_GOOD;
        case (mut)
            MUT_MAGIC:
            begin
                idx = $urandom_range(0, 3);
                image_buf[idx] ^= 8'($urandom_range(1, 255));
            end
            MUT_DATA:
            begin
                do
                    image_buf[5] = 8'($urandom);
                while (image_buf[5] == DATA_LSB);
            end
            MUT_CLASS:
                image_buf[4] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(3, 255));
            MUT_EHSIZE:     eh_size = 16'($urandom_range(0, hsize - 1));
            MUT_PH_ENT:     ph_shape = TBL_NO_ENTSIZE;
            MUT_PH_RANGE:   ph_shape = TBL_OUT_OF_RANGE;
            MUT_SH_ENT:     sh_shape = TBL_NO_ENTSIZE;
            MUT_SH_RANGE:   sh_shape = TBL_OUT_OF_RANGE;
            MUT_NO_TABLES:
            begin
                ph_shape = TBL_EMPTY;
                sh_shape = TBL_EMPTY;
            end
            default: ;
        endcase
        gen_table(is64, ph_shape, ph_off, ph_ent, ph_cnt);
        gen_table(is64, sh_shape, sh_off, sh_ent, sh_cnt);
        if (is64)
        begin
            put_le(32, ph_off, 8);
            put_le(40, sh_off, 8);
            put_le(52, eh_size, 2);
            put_le(54, ph_ent, 2);
            put_le(56, ph_cnt, 2);
            put_le(58, sh_ent, 2);
            put_le(60, sh_cnt, 2);
        end
        else
        begin
            put_le(28, ph_off, 4);
            put_le(32, sh_off, 4);
            put_le(40, eh_size, 2);
            put_le(42, ph_ent, 2);
            put_le(44, ph_cnt, 2);
            put_le(46, sh_ent, 2);
            put_le(48, sh_cnt, 2);
        end
    endfunction

    function automatic int natural_len();
        if (cfg_image_size == 0)
            return 1;
        return (cfg_image_size < HDR_BYTES) ? int'(cfg_image_size) : HDR_BYTES;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len != 0)
            begin
                @(negedge clk);
                in_ch.valid = 1'b0;
                repeat (gap_len - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid       = 1'b1;
        in_ch.header_byte = b;
        in_ch.last_byte   = last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (hdr_count < HDR_BYTES)
        begin
            hdr_mem[hdr_count] = b;
            hdr_count++;
        end
        if (last)
        begin
            expected_results.push_back(predict_result());
            hdr_count = 0;
        end
    endtask

    task automatic stream_image(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (i < HDR_BYTES)
                push_byte(image_buf[i], i == n - 1);
            else
                push_byte(8'($urandom), i == n - 1);
        end
    endtask

    task automatic send_header(input bit is64, input hdr_mutation_t mut, input int n);
        build_header(is64, mut);
        stream_image(n);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes a register while the block is idle, then reads the size back.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] rdata;
        wait_idle();
        apb_access(1'b1, addr, value, rdata);
        if (addr == ADDR_IMAGE_SIZE)
            cfg_image_size = value;
        apb_access(1'b0, ADDR_IMAGE_SIZE, '0, rdata);
        if (rdata !== cfg_image_size)
        begin
            $display("%0t: image_size readback mismatch: expected %0h, got %0h",
                     $time, cfg_image_size, rdata);
            errors++;
        end
    endtask

    // Result channel stalls in stretches of differing density.
    initial
    begin : out_stall_pattern
        stall_mode_t mode;
        int          left;
        out_ch.ready = 1'b0;
        mode = STALL_NONE;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 2));
                left = $urandom_range(10, 150);
            end
            left--;
            case (mode)
                STALL_NONE:   out_ch.ready = 1'b1;
                STALL_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
                default:      out_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        elf_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none expected: expected nothing, got status %0d",
                         $time, out_ch.status);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                compare_field("status", want.status, out_ch.status);
                compare_field("is_64bit", want.is_64bit, out_ch.is_64bit);
                compare_field("machine", want.machine, out_ch.machine);
                compare_field("file_type", want.file_type, out_ch.file_type);
                compare_field("entry_point", want.entry_point, out_ch.entry_point);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    task automatic test_too_small();
        write_register(ADDR_IMAGE_SIZE, 32'd0);
        send_header(1'b0, MUT_NONE, 1);
        write_register(ADDR_IMAGE_SIZE, 32'd15);
        send_header(1'b1, MUT_NONE, 15);
    endtask

    task automatic test_ident_checks();
        write_register(ADDR_IMAGE_SIZE, IDENT_BYTES);
        send_header(1'b0, MUT_NONE, 16);
        send_header(1'b1, MUT_MAGIC, 16);
        send_header(1'b0, MUT_DATA, 16);
        send_header(1'b1, MUT_CLASS, 16);
    endtask

    task automatic test_header_fit();
        write_register(ADDR_IMAGE_SIZE, 32'd51);
        send_header(1'b0, MUT_NONE, 51);
        write_register(ADDR_IMAGE_SIZE, 32'd52);
        send_header(1'b0, MUT_NONE, 52);
        send_header(1'b0, MUT_EHSIZE, 52);
        write_register(ADDR_IMAGE_SIZE, 32'd63);
        send_header(1'b1, MUT_NONE, 63);
        write_register(ADDR_IMAGE_SIZE, 32'd64);
        send_header(1'b1, MUT_NONE, 64);
        send_header(1'b1, MUT_EHSIZE, 64);
    endtask

    task automatic test_table_checks();
        write_register(ADDR_IMAGE_SIZE, 32'hFFFF_FFFF);
        send_header(1'b0, MUT_PH_ENT, 64);
        send_header(1'b1, MUT_PH_RANGE, 64);
        send_header(1'b1, MUT_SH_ENT, 64);
        send_header(1'b0, MUT_SH_RANGE, 64);
        send_header(1'b1, MUT_NO_TABLES, 64);
        // Entry of all ones, and a stream that runs past the stored window.
        build_header(1'b1, MUT_NONE);
        put_le(24, '1, 8);
        stream_image(70);
    endtask

    // Bytes never delivered must read as zero, even where an earlier image left data.
    task automatic test_short_stream();
        write_register(ADDR_IMAGE_SIZE, 32'd4096);
        send_header(1'b0, MUT_NONE, 20);
        send_header(1'b1, MUT_NONE, 40);
        send_header(1'b0, MUT_NONE, 64);
    endtask

    task automatic test_register_map();
        write_register(ADDR_UNUSED, $urandom);
        send_header(1'b0, MUT_NONE, natural_len());
    endtask

    task automatic test_random_images();
        int            start_bytes, n_images, len, pick;
        logic [31:0]   size;
        hdr_mutation_t mut;
        bit            is64;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       size = $urandom_range(0, 20);
                1, 2:    size = $urandom_range(48, 70);
                3, 4, 5,
                6:       size = $urandom_range(64, 65535);
                7, 8:    size = $urandom;
                default: size = 32'hFFFF_FFFF;
            endcase
            write_register(ADDR_IMAGE_SIZE, size);
            n_images = $urandom_range(1, 4);
            repeat (n_images)
            begin
                is64 = 1'($urandom_range(0, 1));
                mut  = ($urandom_range(0, 2) == 0) ? MUT_NONE
                       : hdr_mutation_t'($urandom_range(1, MUT_NO_TABLES));
                build_header(is64, mut);
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    for (int i = 0; i < HDR_BYTES; i++)
                        image_buf[i] = 8'($urandom);
                    len = $urandom_range(1, 80);
                end
                else if (pick == 1)
                    len = $urandom_range(1, 80);
                else
                    len = natural_len();
                stream_image(len);
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.header_byte = '0;
        in_ch.last_byte   = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_too_small();
        test_ident_checks();
        test_header_fit();
        test_table_checks();
        test_short_stream();
        test_register_map();
        test_random_images();

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
